// ----- sv/rgo_pkg.sv -----
// ----------------------------------------------------------------------------
// rgo_pkg
// Shared widths, constants, register indexes and helpers of the raster grid
// overlay pipeline.
// ----------------------------------------------------------------------------
package rgo_pkg;

  localparam int TICK_HALF     = 2;
  localparam int NOFF          = 2 * TICK_HALF + 1;
  localparam int IMAGE_SAMPLES = 4096;
  localparam int IMAGE_LINES   = 4096;

  localparam int POS_W      = 13;
  localparam int INC_W      = 16;
  localparam int HW_W       = 7;
  localparam int PIX_W      = 32;
  localparam int MODE_W     = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic signed [PIX_W-1:0] HIGH_SAT_CODE = 32'sh7FFF_FFFF;

  // signed width of window bounds, width of signed dividend
  localparam int AW    = INC_W;
  localparam int XW    = INC_W + 2;
  localparam int DVD_W = INC_W + 1;
  // one stage per quotient bit plus the sign fixup
  localparam int DIV_STG = DVD_W + 1;

  // pipeline stage numbers of the top level
  localparam int ST_EVAL = DIV_STG + 1;
  localparam int ST_OUT  = ST_EVAL + 1;
  localparam int NSTG    = ST_OUT + 1;

  // mode_flags bits
  localparam int MODE_TICK    = 0;
  localparam int MODE_DIAG    = 1;
  localparam int MODE_OUTLINE = 2;
  localparam int MODE_PIX_BG  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE        = 3'd0,
    CFG_SAMPLE_INC  = 3'd1,
    CFG_SAMPLE_PH   = 3'd2,
    CFG_LINE_INC    = 3'd3,
    CFG_LINE_PH     = 3'd4,
    CFG_HALF_WIDTH  = 3'd5,
    CFG_GRID_VAL    = 3'd6,
    CFG_BG_VAL      = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic             neg;
    logic [DVD_W-1:0] mag;
  } dvd_t;

  // left end of the search window for the leftmost tick offset
  function automatic logic signed [AW-1:0] win_base(
    input logic [POS_W-1:0] pos,
    input logic [HW_W-1:0]  hw
  );
    win_base = $signed(AW'(pos)) - $signed(AW'(TICK_HALF)) - $signed(AW'(hw));
  endfunction

endpackage

// ----- sv/rgo_mod.sv -----
// ----------------------------------------------------------------------------
// rgo_mod
// Pipelined floored remainder of a signed dividend by a 16-bit divisor:
// one restoring step per stage, then a sign fixup stage.
// ----------------------------------------------------------------------------
module rgo_mod (
  input  logic                           clk_i,
  input  logic [rgo_pkg::DIV_STG-1:0]    en_i,
  input  rgo_pkg::dvd_t                  dvd_i,
  input  logic [rgo_pkg::INC_W-1:0]      div_i,
  output logic [rgo_pkg::INC_W-1:0]      rem_o
);
  import rgo_pkg::*;

  logic [INC_W-1:0] rem_q [DVD_W];
  logic [INC_W-1:0] rem_d [DVD_W];
  logic [DVD_W-1:0] sh_q  [DVD_W];
  logic [DVD_W-1:0] sh_d  [DVD_W];
  logic             neg_q [DVD_W];
  logic             neg_d [DVD_W];
  logic [INC_W-1:0] fix_q, fix_d;

  logic [INC_W:0]   trial;
  logic [INC_W-1:0] prem;
  logic [DVD_W-1:0] psh;
  logic             pneg;

  always_comb begin
    for (int k = 0; k < DVD_W; k++) begin
      if (k == 0) begin
        prem = '0;
        psh  = dvd_i.mag;
        pneg = dvd_i.neg;
      end else begin
        prem = rem_q[k-1];
        psh  = sh_q[k-1];
        pneg = neg_q[k-1];
      end
      trial = {prem, psh[DVD_W-1]};
      if (trial >= {1'b0, div_i}) begin
        trial = trial - {1'b0, div_i};
      end
      rem_d[k] = trial[INC_W-1:0];
      sh_d[k]  = {psh[DVD_W-2:0], 1'b0};
      neg_d[k] = pneg;
    end
    // floor the remainder of a negative dividend
    if (neg_q[DVD_W-1] && (rem_q[DVD_W-1] != '0)) begin
      fix_d = div_i - rem_q[DVD_W-1];
    end else begin
      fix_d = rem_q[DVD_W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < DVD_W; k++) begin
      if (en_i[k]) begin
        rem_q[k] <= rem_d[k];
        sh_q[k]  <= sh_d[k];
        neg_q[k] <= neg_d[k];
      end
    end
    if (en_i[DIV_STG-1]) begin
      fix_q <= fix_d;
    end
  end

  assign rem_o = fix_q;

endmodule

// ----- sv/rgo_axis.sv -----
// ----------------------------------------------------------------------------
// rgo_axis
// Grid line test of one axis at every tick offset around a position, from
// the floored distance to the first grid coordinate of the window.
// ----------------------------------------------------------------------------
module rgo_axis (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [rgo_pkg::POS_W-1:0]   pos_i,
  input  logic [rgo_pkg::INC_W-1:0]   dist_i,
  input  logic [rgo_pkg::INC_W-1:0]   tgt_i,
  input  logic [rgo_pkg::INC_W-1:0]   inc_i,
  input  logic [rgo_pkg::HW_W-1:0]    hw_i,
  output logic [rgo_pkg::NOFF-1:0]    hit_o
);
  import rgo_pkg::*;

  logic signed [AW-1:0] a0, aj, bj;
  logic [INC_W-1:0]     dj;
  logic [HW_W:0]        w2;
  logic                 cond;
  logic [NOFF-1:0]      hit_d, hit_q;

  always_comb begin
    a0    = win_base(pos_i, hw_i);
    w2    = {hw_i, 1'b0};
    dj    = dist_i;
    hit_d = '0;
    for (int j = 0; j < NOFF; j++) begin
      aj = a0 + $signed(AW'(j));
      bj = aj + $signed(AW'(w2));
      if (j != 0) begin
        dj = (dj == '0) ? inc_i - 1'b1 : dj - 1'b1;
      end
      // negative coordinates only match a zero phase
      if ((tgt_i == '0) || !aj[AW-1]) begin
        cond = (dj <= INC_W'(w2));
      end else begin
        cond = !bj[AW-1] && (tgt_i <= $unsigned(bj));
      end
      hit_d[j] = (inc_i != '0) && cond;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit_q <= hit_d;
    end
  end

  assign hit_o = hit_q;

endmodule

// ----- sv/raster_grid_overlay.sv -----
// Throughput: one pixel per cycle while the output is ready; each stage
// advances when it is empty or the next one advances, so bubbles close up
// while the output is stalled. Depth is set by the 17-stage restoring remainder
// pipeline plus its fixup. Reset clears all valid bits and loads the register
// defaults.
// ----------------------------------------------------------------------------
// raster_grid_overlay
// Draws an image-space grid, tick marks and an outline frame over a pixel
// stream.
// ----------------------------------------------------------------------------
module raster_grid_overlay (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rgo_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [rgo_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [rgo_pkg::POS_W-1:0]           sample_pos_i,
  input  logic [rgo_pkg::POS_W-1:0]           line_pos_i,
  input  logic signed [rgo_pkg::PIX_W-1:0]    pixel_in_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [rgo_pkg::PIX_W-1:0]    pixel_out_o,
  output logic                                grid_hit_o
);
  import rgo_pkg::*;

  logic [MODE_W-1:0]       mode_q;
  logic [INC_W-1:0]        s_inc_q, s_ph_q, l_inc_q, l_ph_q;
  logic [HW_W-1:0]         hw_q;
  logic signed [PIX_W-1:0] grid_val_q, bg_val_q;

  logic [NSTG-1:0]         v_q;
  logic [NSTG:0]           rdy;

  logic [POS_W-1:0]        s_q   [ST_OUT];
  logic [POS_W-1:0]        l_q   [ST_OUT];
  logic signed [PIX_W-1:0] pix_q [ST_OUT];

  dvd_t                    s_dvd_q, s_tdv_q, l_dvd_q, l_tdv_q;
  dvd_t                    s_dvd_d, l_dvd_d;
  logic [INC_W-1:0]        s_dist, s_tgt, l_dist, l_tgt;
  logic [NOFF-1:0]         hs, hl;

  logic signed [PIX_W-1:0] pix_out_q, pix_out_d;
  logic                    hit_q, hit_d;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= '0;
      s_inc_q    <= INC_W'(1);
      s_ph_q     <= '0;
      l_inc_q    <= INC_W'(1);
      l_ph_q     <= '0;
      hw_q       <= '0;
      grid_val_q <= '0;
      bg_val_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MODE:       mode_q     <= cfg_data_i[MODE_W-1:0];
        CFG_SAMPLE_INC: s_inc_q    <= cfg_data_i[INC_W-1:0];
        CFG_SAMPLE_PH:  s_ph_q     <= cfg_data_i[INC_W-1:0];
        CFG_LINE_INC:   l_inc_q    <= cfg_data_i[INC_W-1:0];
        CFG_LINE_PH:    l_ph_q     <= cfg_data_i[INC_W-1:0];
        CFG_HALF_WIDTH: hw_q       <= cfg_data_i[HW_W-1:0];
        CFG_GRID_VAL:   grid_val_q <= $signed(cfg_data_i[PIX_W-1:0]);
        CFG_BG_VAL:     bg_val_q   <= $signed(cfg_data_i[PIX_W-1:0]);
        default: ;
      endcase
    end
  end

  // stage handshake: a stage loads when empty or when it drains
  always_comb begin
    rdy[NSTG] = out_ready_i;
    for (int k = NSTG - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign in_ready_o = rdy[0];

  // dividends: phase minus window base, and phase itself for the target
  function automatic dvd_t mk_dvd(
    input logic [POS_W-1:0] pos,
    input logic [INC_W-1:0] ph,
    input logic [HW_W-1:0]  hw
  );
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] ax;
    x  = $signed({2'b00, ph}) - XW'(win_base(pos, hw));
    ax = x[XW-1] ? -x : x;
    mk_dvd.neg = x[XW-1];
    mk_dvd.mag = ax[DVD_W-1:0];
  endfunction

  assign s_dvd_d = mk_dvd(sample_pos_i, s_ph_q, hw_q);
  assign l_dvd_d = mk_dvd(line_pos_i, l_ph_q, hw_q);

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      s_dvd_q  <= s_dvd_d;
      l_dvd_q  <= l_dvd_d;
      s_tdv_q  <= '{neg: 1'b0, mag: DVD_W'(s_ph_q)};
      l_tdv_q  <= '{neg: 1'b0, mag: DVD_W'(l_ph_q)};
      s_q[0]   <= sample_pos_i;
      l_q[0]   <= line_pos_i;
      pix_q[0] <= pixel_in_i;
    end
    for (int k = 1; k < ST_OUT; k++) begin
      if (rdy[k]) begin
        s_q[k]   <= s_q[k-1];
        l_q[k]   <= l_q[k-1];
        pix_q[k] <= pix_q[k-1];
      end
    end
  end

  rgo_mod u_s_dist (
    .clk_i (clk_i), .en_i (rdy[DIV_STG:1]), .dvd_i (s_dvd_q),
    .div_i (s_inc_q), .rem_o (s_dist)
  );
  rgo_mod u_s_tgt (
    .clk_i (clk_i), .en_i (rdy[DIV_STG:1]), .dvd_i (s_tdv_q),
    .div_i (s_inc_q), .rem_o (s_tgt)
  );
  rgo_mod u_l_dist (
    .clk_i (clk_i), .en_i (rdy[DIV_STG:1]), .dvd_i (l_dvd_q),
    .div_i (l_inc_q), .rem_o (l_dist)
  );
  rgo_mod u_l_tgt (
    .clk_i (clk_i), .en_i (rdy[DIV_STG:1]), .dvd_i (l_tdv_q),
    .div_i (l_inc_q), .rem_o (l_tgt)
  );

  rgo_axis u_s_axis (
    .clk_i (clk_i), .en_i (rdy[ST_EVAL]), .pos_i (s_q[ST_EVAL-1]),
    .dist_i (s_dist), .tgt_i (s_tgt), .inc_i (s_inc_q), .hw_i (hw_q),
    .hit_o (hs)
  );
  rgo_axis u_l_axis (
    .clk_i (clk_i), .en_i (rdy[ST_EVAL]), .pos_i (l_q[ST_EVAL-1]),
    .dist_i (l_dist), .tgt_i (l_tgt), .inc_i (l_inc_q), .hw_i (hw_q),
    .hit_o (hl)
  );

  // combine axes, pick background, apply outline
  logic signed [XW-1:0] ss, ls, w2s;
  logic                 frame;

  always_comb begin
    hit_d = 1'b0;
    if (!mode_q[MODE_TICK]) begin
      hit_d = hs[TICK_HALF] || hl[TICK_HALF];
    end else if (!mode_q[MODE_DIAG]) begin
      hit_d = (hl[TICK_HALF] && (|hs)) || (hs[TICK_HALF] && (|hl));
    end else begin
      for (int j = 0; j < NOFF; j++) begin
        hit_d = hit_d || (hl[j] && (hs[j] || hs[NOFF-1-j]));
      end
    end

    ss    = $signed(XW'(s_q[ST_EVAL]));
    ls    = $signed(XW'(l_q[ST_EVAL]));
    w2s   = $signed(XW'({hw_q, 1'b0}));
    frame = (ls - XW'(1) <= w2s) || (ls >= XW'(IMAGE_LINES) - w2s) ||
            (ss - XW'(1) <= w2s) || (ss >= XW'(IMAGE_SAMPLES) - w2s);

    if (hit_d) begin
      pix_out_d = grid_val_q;
    end else if (mode_q[MODE_PIX_BG]) begin
      pix_out_d = pix_q[ST_EVAL];
    end else begin
      pix_out_d = bg_val_q;
    end
    if (mode_q[MODE_OUTLINE] && frame) begin
      pix_out_d = HIGH_SAT_CODE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[ST_OUT]) begin
      pix_out_q <= pix_out_d;
      hit_q     <= hit_d;
    end
  end

  assign out_valid_o = v_q[ST_OUT];
  assign pixel_out_o = pix_out_q;
  assign grid_hit_o  = hit_q;

  a_empty_out_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with an empty output stage");

  a_in_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> v_q[0])
    else $error("accepted pixel missing from first stage");

  a_out_fills : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[ST_EVAL] && rdy[ST_OUT] |=> out_valid_o)
    else $error("evaluated pixel lost before the output stage");

endmodule

// ----- tb/sv/tb_raster_grid_overlay.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_raster_grid_overlay
// Self-checking bench: drives pixels through the overlay under a series of
// register settings, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module tb_raster_grid_overlay;
  import rgo_pkg::*;

  typedef struct {
    logic signed [PIX_W-1:0] pix;
    logic                    hit;
  } overlay_res_t;

  typedef struct {
    logic [POS_W-1:0]        s;
    logic [POS_W-1:0]        l;
    logic signed [PIX_W-1:0] pix;
    bit                      typed;
    overlay_res_t            res;
  } pix_row_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0]   cfg_data_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic [POS_W-1:0]        sample_pos_i = '0;
  logic [POS_W-1:0]        line_pos_i = '0;
  logic signed [PIX_W-1:0] pixel_in_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic signed [PIX_W-1:0] pixel_out_o;
  logic                    grid_hit_o;

  // shadow copy of the block's registers
  logic [MODE_W-1:0]       g_mode;
  logic [INC_W-1:0]        g_s_inc, g_s_ph, g_l_inc, g_l_ph;
  logic [HW_W-1:0]         g_hw;
  logic signed [PIX_W-1:0] g_grid_val, g_bg_val;

  overlay_res_t expected_q[$];
  int  n_errors = 0;
  int  n_pixels = 0;
  int  n_hits = 0;
  int  n_settings = 0;
  bit  calm = 0;
  bit  long_hold = 0;

  raster_grid_overlay uut (.*);

  always #5 clk_i = ~clk_i;

  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic bit on_axis(longint p, logic [INC_W-1:0] inc, logic [INC_W-1:0] ph);
    longint target;
    longint w;
    if (inc == 0) return 0;
    w = longint'(g_hw);
    target = longint'(ph) % longint'(inc);
    for (longint y = p - w; y <= p + w; y++) begin
      if (y % longint'(inc) == target) return 1;
    end
    return 0;
  endfunction

  function automatic bit grid_covers(longint s, longint l);
    if (!g_mode[MODE_TICK])
      return on_axis(s, g_s_inc, g_s_ph) || on_axis(l, g_l_inc, g_l_ph);
    for (longint k = -TICK_HALF; k <= TICK_HALF; k++) begin
      if (g_mode[MODE_DIAG]) begin
        if (on_axis(l + k, g_l_inc, g_l_ph) &&
            (on_axis(s + k, g_s_inc, g_s_ph) || on_axis(s - k, g_s_inc, g_s_ph)))
          return 1;
      end else begin
        if (on_axis(l, g_l_inc, g_l_ph) && on_axis(s + k, g_s_inc, g_s_ph)) return 1;
        if (on_axis(s, g_s_inc, g_s_ph) && on_axis(l + k, g_l_inc, g_l_ph)) return 1;
      end
    end
    return 0;
  endfunction

  function automatic overlay_res_t overlay_pixel(logic [POS_W-1:0] sp, logic [POS_W-1:0] lp,
                                                 logic signed [PIX_W-1:0] pix);
    overlay_res_t r;
    longint s = longint'(sp);
    longint l = longint'(lp);
    longint w2 = 2 * longint'(g_hw);
    r.hit = grid_covers(s, l);
    r.pix = r.hit ? g_grid_val : (g_mode[MODE_PIX_BG] ? pix : g_bg_val);
    if (g_mode[MODE_OUTLINE] && (l - 1 <= w2 || l >= IMAGE_LINES - w2 ||
        s - 1 <= w2 || s - 1 >= IMAGE_SAMPLES - w2 - 1))
      r.pix = HIGH_SAT_CODE;
    return r;
  endfunction

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 16);
  endfunction

  // leaves the write enable high; the caller lowers it after the batch
  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_MODE:       g_mode     = val[MODE_W-1:0];
      CFG_SAMPLE_INC: g_s_inc    = val[INC_W-1:0];
      CFG_SAMPLE_PH:  g_s_ph     = val[INC_W-1:0];
      CFG_LINE_INC:   g_l_inc    = val[INC_W-1:0];
      CFG_LINE_PH:    g_l_ph     = val[INC_W-1:0];
      CFG_HALF_WIDTH: g_hw       = val[HW_W-1:0];
      CFG_GRID_VAL:   g_grid_val = val;
      default:        g_bg_val   = val;
    endcase
  endtask

  task automatic wait_drained();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic configure(logic [MODE_W-1:0] mode, logic [INC_W-1:0] s_inc,
                           logic [INC_W-1:0] s_ph, logic [INC_W-1:0] l_inc,
                           logic [INC_W-1:0] l_ph, logic [HW_W-1:0] hw,
                           logic [PIX_W-1:0] gv, logic [PIX_W-1:0] bv);
    // stop offering before the pipeline drains
    in_valid_i <= 1'b0;
    wait_drained();
    write_reg(CFG_MODE, CFG_DATA_W'(mode));
    write_reg(CFG_SAMPLE_INC, CFG_DATA_W'(s_inc));
    write_reg(CFG_SAMPLE_PH, CFG_DATA_W'(s_ph));
    write_reg(CFG_LINE_INC, CFG_DATA_W'(l_inc));
    write_reg(CFG_LINE_PH, CFG_DATA_W'(l_ph));
    write_reg(CFG_HALF_WIDTH, CFG_DATA_W'(hw));
    write_reg(CFG_GRID_VAL, gv);
    write_reg(CFG_BG_VAL, bv);
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  // offer one pixel; the expectation is queued at the transfer
  task automatic send_pixel(pix_row_t row);
    int gap = draw_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    sample_pos_i <= row.s;
    line_pos_i   <= row.l;
    pixel_in_i   <= row.pix;
    do @(posedge clk_i); while (!in_ready_o);
    expected_q.push_back(row.typed ? row.res : overlay_pixel(row.s, row.l, row.pix));
    n_pixels++;
  endtask

  function automatic logic [POS_W-1:0] rand_pos();
    case ($urandom_range(0, 9))
      0:       return POS_W'($urandom_range(0, 8191));
      1:       return POS_W'($urandom_range(0, 6));
      2:       return POS_W'($urandom_range(4088, 4097));
      default: return POS_W'($urandom_range(1, 4096));
    endcase
  endfunction

  task automatic send_random(int n);
    pix_row_t row;
    row.typed = 0;
    repeat (n) begin
      row.s   = rand_pos();
      row.l   = rand_pos();
      row.pix = $urandom();
      send_pixel(row);
    end
  endtask

  function automatic logic [INC_W-1:0] rand_inc();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return INC_W'($urandom_range(1, 65535));
      default: return INC_W'($urandom_range(1, 40));
    endcase
  endfunction

  // receiver: random stalls, one long hold-off on request, and the check
  initial begin
    overlay_res_t exp_r;
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = long_hold ? 400 : draw_gap();
      long_hold = 0;
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      if (expected_q.size() == 0) begin
        $display("%t: unexpected result pixel=%h hit=%b", $time, pixel_out_o, grid_hit_o);
        n_errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (grid_hit_o) n_hits++;
        if (pixel_out_o !== exp_r.pix) begin
          $display("%t: pixel_out expected %h actual %h", $time, exp_r.pix, pixel_out_o);
          n_errors++;
        end
        if (grid_hit_o !== exp_r.hit) begin
          $display("%t: grid_hit expected %b actual %b", $time, exp_r.hit, grid_hit_o);
          n_errors++;
        end
      end
    end
  end

  initial begin
    // reset settings draw every position as grid with code zero
    pix_row_t reset_rows[8] = '{
      '{13'd1,    13'd1,    32'sh0000_0000, 1, '{32'sh0, 1'b1}},
      '{13'd4096, 13'd4096, 32'shFFFF_FFFF, 1, '{32'sh0, 1'b1}},
      '{13'd8191, 13'd8191, 32'sh7FFF_FFFF, 1, '{32'sh0, 1'b1}},
      '{13'd0,    13'd0,    32'sh8000_0000, 1, '{32'sh0, 1'b1}},
      '{13'd4096, 13'd1,    32'sh1234_5678, 1, '{32'sh0, 1'b1}},
      '{13'd1,    13'd4096, 32'sh0000_0001, 1, '{32'sh0, 1'b1}},
      '{13'h1555, 13'h0AAA, 32'sh5555_5555, 1, '{32'sh0, 1'b1}},
      '{13'h0AAA, 13'h1555, 32'shAAAA_AAAA, 1, '{32'sh0, 1'b1}}
    };
    logic [MODE_W-1:0] mode;
    logic [INC_W-1:0]  si, li;

    g_mode = '0; g_s_inc = INC_W'(1); g_s_ph = '0; g_l_inc = INC_W'(1); g_l_ph = '0;
    g_hw = '0; g_grid_val = '0; g_bg_val = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (reset_rows[i]) send_pixel(reset_rows[i]);

    // zero sample spacing, phase above spacing on lines
    configure(4'b0000, 16'd0, 16'd0, 16'd7, 16'd23, 7'd0, 32'h1111_1111, 32'h2222_2222);
    send_random(3);
    // crosses, then diagonals, then diagonal flag alone
    configure(4'b1001, 16'd5, 16'd1, 16'd6, 16'd2, 7'd0, 32'h3333_3333, 32'h4444_4444);
    send_random(3);
    configure(4'b1011, 16'd5, 16'd4, 16'd5, 16'd0, 7'd1, 32'h8000_0000, 32'h7FFF_FFFF);
    send_random(3);
    configure(4'b1010, 16'd9, 16'd3, 16'd4, 16'd1, 7'd0, 32'h0000_0001, 32'hFFFF_FFFF);
    send_random(3);
    // outline with wide lines and all-ones extremes
    configure(4'b1111, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFE, 7'h7F,
              32'h7FFF_FFFF, 32'h8000_0000);
    send_random(4);

    for (int ph = 0; ph < 12; ph++) begin
      mode = MODE_W'($urandom_range(0, 15));
      si = rand_inc();
      li = rand_inc();
      configure(mode, si,
                INC_W'($urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, si)),
                li,
                INC_W'($urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, li)),
                HW_W'($urandom_range(0, 7) == 0 ? $urandom_range(0, 127)
                                                : $urandom_range(0, 4)),
                $urandom(), $urandom());
      calm = (ph % 4 == 1);
      if (ph == 5) long_hold = 1;
      send_random(75);
      calm = 0;
      in_valid_i <= 1'b0;
    end

    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    $display("Overlaid %0d pixels under %0d register settings, %0d grid hits.",
             n_pixels, n_settings, n_hits);
    if (n_errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
